FILE: rtl/core/dpat_pkg.sv
// ----------------------------------------------------------------------------
// dpat_pkg: shared types and constants of the address translator
// Field widths, command and status codes, beat payload structs and the
// frame search helpers.
// ----------------------------------------------------------------------------
package dpat_pkg;

    localparam int unsigned PROCESS_SLOTS     = 16;
    localparam int unsigned PAGES_PER_PROCESS = 32;
    localparam int unsigned FRAME_COUNT       = 128;
    localparam int unsigned OFFSET_BITS       = 23;

    localparam int unsigned CMD_W      = 3;
    localparam int unsigned SLOT_W     = 4;
    localparam int unsigned PAGE_W     = 5;
    localparam int unsigned VA_W       = 28;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned MAP_IDX_W  = 4;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned FRAME_W    = 7;
    localparam int unsigned PA_W       = 31;
    localparam int unsigned TBL_AW     = SLOT_W + PAGE_W;
    localparam int unsigned TBL_DEPTH  = PROCESS_SLOTS * PAGES_PER_PROCESS;
    localparam int unsigned MAP_BYTES  = FRAME_COUNT / 8;
    localparam int unsigned MEM_BASE   = 256 * PROCESS_SLOTS + 16;
    localparam int unsigned ENTRY_VALID_BIT = 7;

    localparam logic [CMD_W-1:0] CMD_LOAD_ENTRY = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOAD_MAP   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_MAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_FRAME   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [SLOT_W-1:0]    process_slot;
        logic [VA_W-1:0]      virtual_address;
        logic [PAGE_W-1:0]    page_index;
        logic [BYTE_W-1:0]    load_value;
        logic [MAP_IDX_W-1:0] map_byte_index;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame_number;
        logic [PA_W-1:0]     physical_address;
        logic                newly_allocated;
    } t_rsp;

    // {found, index} of the lowest clear bit
    function automatic logic [3:0] first_zero8(input logic [7:0] v);
        logic [3:0] res;
        res = '0;
        for (int b = 7; b >= 0; b--) begin
            if (!v[b]) begin
                res = {1'b1, 3'(b)};
            end
        end
        return res;
    endfunction

    // {found, index} of the lowest map byte holding a free frame
    function automatic logic [MAP_IDX_W:0] first_free_byte(input logic [FRAME_COUNT-1:0] map);
        logic [MAP_IDX_W:0] res;
        res = '0;
        for (int i = MAP_BYTES - 1; i >= 0; i--) begin
            if (map[i*8 +: 8] != 8'hFF) begin
                res = {1'b1, MAP_IDX_W'(i)};
            end
        end
        return res;
    endfunction

    // Non-translated answers carry zero frame and address
    function automatic t_rsp make_rsp(input logic [STATUS_W-1:0]    status,
                                      input logic [FRAME_W-1:0]     frame,
                                      input logic [OFFSET_BITS-1:0] offset,
                                      input logic                   fresh);
        t_rsp r;
        r = '0;
        r.status = status;
        if (status == STATUS_OK) begin
            r.frame_number     = frame;
            r.physical_address = {1'b0, frame, offset} + PA_W'(MEM_BASE);
            r.newly_allocated  = fresh;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/dpat_req_if.sv
// ----------------------------------------------------------------------------
// dpat_req_if: command channel of the address translator
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface dpat_req_if;
    logic          valid;
    logic          ready;
    dpat_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/dpat_rsp_if.sv
// ----------------------------------------------------------------------------
// dpat_rsp_if: result channel of the address translator
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface dpat_rsp_if;
    logic          valid;
    logic          ready;
    dpat_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/demand_paged_address_translator.sv
// ----------------------------------------------------------------------------
// demand_paged_address_translator: page table translation with frame map
// Page entries of all process slots sit in one 512 x 8 synchronous RAM; the
// 128-bit frame-used map is held in flops beside it.
// ----------------------------------------------------------------------------
// Usage: commands arrive as beats on i_req, one result beat per command
// leaves on o_rsp, in order. Both are valid/ready channels.
// Load entry, load map byte and unknown commands form their result in the
// accept cycle. Translations also pass through a lookup state: table read,
// then check, frame pick and write-back. Release walks the slot's 32
// entries through the RAM read port after the accept, while zeroes are
// written one entry behind.
// A formed result sits in a pending register and moves into the o_rsp
// register at the first edge where that register is free. i_req is held
// off while the pending register is occupied, so a new command is taken
// only once the last result has left it, and never while a translation or
// release is in progress. When o_rsp stalls, both registers fill and i_req
// stays held off until o_rsp drains.
// After reset the map is cleared at once and the table RAM is cleared by a
// pass over all 512 entries, during which no command is accepted.
// ----------------------------------------------------------------------------
module demand_paged_address_translator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dpat_req_if.sink  i_req,
    dpat_rsp_if.source o_rsp
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_RELEASE
    } t_state;

    t_state r_state;

    logic [dpat_pkg::TBL_AW-1:0]      r_clr;
    logic [dpat_pkg::PAGE_W:0]        r_walk;
    logic [dpat_pkg::FRAME_COUNT-1:0] r_map;
    logic [dpat_pkg::CMD_W-1:0]       r_cmd;
    logic [dpat_pkg::SLOT_W-1:0]      r_slot;
    logic [dpat_pkg::PAGE_W-1:0]      r_vpn;
    logic [dpat_pkg::OFFSET_BITS-1:0] r_off;
    logic [dpat_pkg::MAP_IDX_W-1:0]   r_fbyte;
    logic                             r_any_free;
    dpat_pkg::t_rsp                   r_res;
    logic                             r_res_valid;
    dpat_pkg::t_rsp                   r_out;
    logic                             r_out_valid;

    logic [dpat_pkg::BYTE_W-1:0] r_tbl [dpat_pkg::TBL_DEPTH];
    logic [dpat_pkg::BYTE_W-1:0] r_rd_data;

    logic                          tbl_we;
    logic [dpat_pkg::TBL_AW-1:0]   tbl_waddr;
    logic [dpat_pkg::BYTE_W-1:0]   tbl_wdata;
    logic [dpat_pkg::TBL_AW-1:0]   tbl_raddr;

    dpat_pkg::t_req                  req;
    logic                            accept;
    logic                            out_free;
    logic [dpat_pkg::PAGE_W-1:0]     req_vpn;
    logic [dpat_pkg::PAGE_W-1:0]     walk_prev;
    logic [7:0]                      free_byte_bits;
    logic [3:0]                      free_bit;
    logic [dpat_pkg::FRAME_W-1:0]    alloc_frame;
    logic [dpat_pkg::MAP_IDX_W:0]    free_byte;
    logic                            entry_valid;

    assign req         = i_req.payload;
    assign i_req.ready = (r_state == ST_IDLE) && !r_res_valid;
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign req_vpn     = req.virtual_address[dpat_pkg::OFFSET_BITS +: dpat_pkg::PAGE_W];
    assign walk_prev   = r_walk[dpat_pkg::PAGE_W-1:0] - 1'b1;

    assign free_byte      = dpat_pkg::first_free_byte(r_map);
    assign free_byte_bits = r_map[{r_fbyte, 3'b000} +: 8];
    assign free_bit       = dpat_pkg::first_zero8(free_byte_bits);
    assign alloc_frame    = {r_fbyte, free_bit[2:0]};
    assign entry_valid    = r_rd_data[dpat_pkg::ENTRY_VALID_BIT];

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // Table RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_waddr] <= tbl_wdata;
        end
        r_rd_data <= r_tbl[tbl_raddr];
    end

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = r_clr;
        tbl_wdata = '0;
        tbl_raddr = {req.process_slot, req_vpn};
        unique case (r_state)
            ST_CLEAR: begin
                tbl_we = 1'b1;
            end
            ST_IDLE: begin
                if (accept && req.cmd == dpat_pkg::CMD_LOAD_ENTRY) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = {req.process_slot, req.page_index};
                    tbl_wdata = req.load_value;
                end
            end
            ST_LOOKUP: begin
                if (!entry_valid && r_cmd == dpat_pkg::CMD_ALLOC && r_any_free) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = {r_slot, r_vpn};
                    tbl_wdata = {1'b1, alloc_frame};
                end
            end
            ST_RELEASE: begin
                // read one entry ahead, zero the one whose data has arrived
                tbl_raddr = {r_slot, r_walk[dpat_pkg::PAGE_W-1:0]};
                if (r_walk != '0) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = {r_slot, walk_prev};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_walk      <= '0;
            r_map       <= '0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // advance the pending result into the output register
            if (out_free) begin
                r_out_valid <= r_res_valid;
                r_out       <= r_res;
            end
            // a new result is only formed while the pending register is empty
            if (out_free && r_res_valid) begin
                r_res_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == dpat_pkg::TBL_AW'(dpat_pkg::TBL_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd      <= req.cmd;
                        r_slot     <= req.process_slot;
                        r_vpn      <= req_vpn;
                        r_off      <= req.virtual_address[dpat_pkg::OFFSET_BITS-1:0];
                        r_fbyte    <= free_byte[dpat_pkg::MAP_IDX_W-1:0];
                        r_any_free <= free_byte[dpat_pkg::MAP_IDX_W];
                        r_walk     <= '0;
                        unique case (req.cmd)
                            dpat_pkg::CMD_READ, dpat_pkg::CMD_ALLOC: begin
                                r_state <= ST_LOOKUP;
                            end
                            dpat_pkg::CMD_RELEASE: begin
                                r_state <= ST_RELEASE;
                            end
                            dpat_pkg::CMD_LOAD_MAP: begin
                                // map MSB is the lowest frame of the byte
                                for (int b = 0; b < 8; b++) begin
                                    r_map[{req.map_byte_index, 3'(b)}] <=
                                        req.load_value[3'(7 - b)];
                                end
                                r_res       <= dpat_pkg::make_rsp(dpat_pkg::STATUS_DONE,
                                                                  '0, '0, 1'b0);
                                r_res_valid <= 1'b1;
                            end
                            default: begin
                                r_res       <= dpat_pkg::make_rsp(dpat_pkg::STATUS_DONE,
                                                                  '0, '0, 1'b0);
                                r_res_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_LOOKUP: begin
                    r_res_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                    if (entry_valid) begin
                        r_res <= dpat_pkg::make_rsp(dpat_pkg::STATUS_OK,
                                                    r_rd_data[dpat_pkg::FRAME_W-1:0],
                                                    r_off, 1'b0);
                    end else if (r_cmd != dpat_pkg::CMD_ALLOC) begin
                        r_res <= dpat_pkg::make_rsp(dpat_pkg::STATUS_NOT_MAPPED,
                                                    '0, '0, 1'b0);
                    end else if (!r_any_free) begin
                        r_res <= dpat_pkg::make_rsp(dpat_pkg::STATUS_NO_FRAME,
                                                    '0, '0, 1'b0);
                    end else begin
                        r_map[alloc_frame] <= 1'b1;
                        r_res <= dpat_pkg::make_rsp(dpat_pkg::STATUS_OK, alloc_frame,
                                                    r_off, 1'b1);
                    end
                end
                ST_RELEASE: begin
                    r_walk <= r_walk + 1'b1;
                    if (r_walk != '0 && entry_valid) begin
                        r_map[r_rd_data[dpat_pkg::FRAME_W-1:0]] <= 1'b0;
                    end
                    if (r_walk == (dpat_pkg::PAGE_W+1)'(dpat_pkg::PAGES_PER_PROCESS)) begin
                        r_res       <= dpat_pkg::make_rsp(dpat_pkg::STATUS_DONE,
                                                          '0, '0, 1'b0);
                        r_res_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
